FILE: rtl/scanner_vibrato_chorus_macros.svh
// Assertion macros for the scanner vibrato / chorus block.
// Taken in by the checker file; needs nothing else.
`ifndef SCANNER_VIBRATO_CHORUS_MACROS_SVH
`define SCANNER_VIBRATO_CHORUS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SVC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SVC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/svc_pkg.sv
// Shared types, constants and tap map function for the scanner vibrato / chorus.
// No dependencies.
package svc_pkg;

   localparam int SECTIONS   = 18;
   localparam int SAMPLE_W   = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int FRAC_BITS  = 28;
   localparam int Q_SHIFT    = 20;
   localparam int ACC_W      = 56;
   localparam int BLEND_W    = 63;

   // Q20 section coefficients, truncated
   localparam logic signed [17:0] COEF_A0 = 18'sd59976;
   localparam logic signed [21:0] COEF_B1 = -22'sd1278034;
   localparam logic signed [19:0] COEF_B2 = 20'sd469363;

   localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   localparam logic [1:0]  MODE_V1 = 2'd0;
   localparam logic [1:0]  MODE_V2 = 2'd1;
   localparam logic [1:0]  MODE_V3 = 2'd2;

   localparam logic [1:0]  MODE_RESET = MODE_V3;
   localparam logic        MIX_RESET  = 1'b1;
   localparam logic [31:0] STEP_RESET = 32'd642784;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_MODE = 2'd0,
      REG_MIX  = 2'd1,
      REG_STEP = 2'd2
   } csr_addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_BLEND,
      ST_DONE
   } state_type;

   // one memory word per section
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] y2;
   } sect_state_type;

   // tap index for a mode and a table position 0..8; unused mode code maps like V3
   function automatic logic [4:0] tap_of(input logic [1:0] mode, input logic [3:0] pos);
      logic [4:0] tap;
      tap = 5'd0;
      case (mode)
         MODE_V1: begin
            case (pos)
               4'd0: tap = 5'd0;
               4'd1: tap = 5'd1;
               4'd2: tap = 5'd2;
               4'd3: tap = 5'd3;
               4'd4: tap = 5'd4;
               4'd5: tap = 5'd5;
               4'd6: tap = 5'd6;
               4'd7: tap = 5'd7;
               default: tap = 5'd8;
            endcase
         end
         MODE_V2: begin
            case (pos)
               4'd0: tap = 5'd0;
               4'd1: tap = 5'd1;
               4'd2: tap = 5'd2;
               4'd3: tap = 5'd4;
               4'd4: tap = 5'd6;
               4'd5: tap = 5'd8;
               4'd6: tap = 5'd9;
               4'd7: tap = 5'd10;
               default: tap = 5'd12;
            endcase
         end
         default: begin
            case (pos)
               4'd0: tap = 5'd0;
               4'd1: tap = 5'd1;
               4'd2: tap = 5'd3;
               4'd3: tap = 5'd6;
               4'd4: tap = 5'd11;
               4'd5: tap = 5'd12;
               4'd6: tap = 5'd15;
               4'd7: tap = 5'd17;
               default: tap = 5'd18;
            endcase
         end
      endcase
      return tap;
   endfunction

endpackage

FILE: rtl/svc_if.sv
// Channel interfaces: sample request, mixed response and register writes.
// Depends on svc_pkg for widths.
interface svc_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [svc_pkg::SAMPLE_W-1:0]    vibrato_sample;
   logic signed [svc_pkg::SAMPLE_W-1:0]    dry_sample;

   modport source (output valid, output vibrato_sample, output dry_sample, input ready);
   modport sink   (input valid, input vibrato_sample, input dry_sample, output ready);
endinterface

interface svc_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [svc_pkg::SAMPLE_W-1:0]    mixed_sample;

   modport source (output valid, output mixed_sample, input ready);
   modport sink   (input valid, input mixed_sample, output ready);
endinterface

interface svc_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [svc_pkg::CSR_ADDR_W-1:0]         addr;
   logic [svc_pkg::CSR_DATA_W-1:0]         wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

FILE: rtl/scanner_vibrato_chorus.sv
// Scanner vibrato / chorus: biquad delay line in RAM, LFO tap scan and mix.
// Depends on svc_pkg, svc_if and svc_ram.
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    vibrato_sample, dry_sample
//   rsp_ch    out   valid/ready    mixed_sample
//   csr_ch    in    valid/ready    addr, wdata (ready always high)
//
// One item at a time, accepted only in the idle state; each section runs a
// multiply state and an accumulate state, since its input is the previous output.
// Section state sits in one RAM word per section; 18 valid bits make unwritten
// words read as zero right after reset, so there is no clearing pass.
// Reset is synchronous; a result waiting on rsp_ch does not block a new item,
// only the write of the next result.
module scanner_vibrato_chorus #(
   parameter int SECTIONS = svc_pkg::SECTIONS
) (
   input  logic     clock,
   input  logic     reset,
   svc_req_if.sink  req_ch,
   svc_rsp_if.source rsp_ch,
   svc_csr_if.sink  csr_ch
);

   localparam int SEC_W = $clog2(SECTIONS);
   localparam int TAP_W = $clog2(SECTIONS + 1);
   localparam int DW    = svc_pkg::SAMPLE_W;
   localparam int AW    = svc_pkg::ACC_W;
   localparam int BW    = svc_pkg::BLEND_W;
   localparam int FB    = svc_pkg::FRAC_BITS;

   // control
   svc_pkg::state_type state_ff, state_in;
   logic [SEC_W-1:0]   sec_ff, sec_in;
   logic [SECTIONS-1:0] valid_ff;
   logic               rd_valid_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [1:0]         mode_ff;
   logic               mix_ff;
   logic [31:0]        step_ff;
   logic [31:0]        phase_ff;

   // datapath
   logic signed [DW-1:0] x_ff, dry_ff, tap0_ff, tap_a_ff, tap_b_ff;
   logic signed [DW-1:0] hold_x1_ff, hold_y1_ff;
   logic [TAP_W-1:0]     idx_a_ff, idx_b_ff;
   logic [FB-1:0]        frac_ff;
   logic signed [AW-1:0] prod0_ff, prod1_ff, prod2_ff;
   logic signed [BW-1:0] blend_a_ff, blend_b_ff;
   logic signed [DW-1:0] rsp_data_ff, rsp_data_in;

   // fsm outputs
   logic req_ready;
   logic ram_rd_en, ram_wr_en;
   logic [SEC_W-1:0] ram_rd_addr;
   logic load_rsp;
   logic accept;

   // ram
   svc_pkg::sect_state_type ram_q, ram_wd, st;

   // combinational datapath
   logic [31:0]          phase_new, phase_fold;
   logic [2:0]           lfo_k;
   logic signed [DW-1:0] x_half;
   logic signed [33:0]   tap_sum;
   logic signed [AW-1:0] acc;
   logic signed [DW-1:0] y_out;
   logic [TAP_W-1:0]     tap_pos;
   logic [FB:0]          weight_a;
   logic signed [BW-1:0] blend_sum;
   logic signed [DW-1:0] blend32;
   logic                 last_sec;

   svc_ram #(
      .WIDTH ($bits(svc_pkg::sect_state_type)),
      .DEPTH (SECTIONS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (sec_ff),
      .wr_data (ram_wd),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   assign accept   = req_ch.valid && req_ready;
   assign last_sec = (sec_ff == SEC_W'(SECTIONS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         svc_pkg::ST_IDLE:  if (req_ch.valid) state_in = svc_pkg::ST_MUL;
         svc_pkg::ST_MUL:   state_in = svc_pkg::ST_ACC;
         svc_pkg::ST_ACC:   state_in = last_sec ? svc_pkg::ST_BLEND : svc_pkg::ST_MUL;
         svc_pkg::ST_BLEND: state_in = svc_pkg::ST_DONE;
         svc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = svc_pkg::ST_IDLE;
         end
         default:           state_in = svc_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_addr = '0;
      load_rsp    = 1'b0;
      case (state_ff)
         svc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ram_rd_en = req_ch.valid;
         end
         svc_pkg::ST_ACC: begin
            ram_wr_en   = 1'b1;
            ram_rd_en   = !last_sec;
            ram_rd_addr = sec_ff + SEC_W'(1);
         end
         svc_pkg::ST_DONE: begin
            load_rsp = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   // LFO advance and fold
   assign phase_new  = phase_ff + step_ff;
   assign phase_fold = phase_new[31] ? ~phase_new : phase_new;
   assign lfo_k      = phase_fold[30:28];
   assign x_half     = req_ch.vibrato_sample >>> 1;

   // section arithmetic
   assign st      = rd_valid_ff ? ram_q : '0;
   assign tap_sum = 34'(x_ff) + (34'(st.x1) <<< 1) + 34'(st.x2);
   assign acc     = prod0_ff - prod1_ff - prod2_ff;
   assign y_out   = acc[svc_pkg::Q_SHIFT +: DW];
   assign tap_pos = TAP_W'(sec_ff) + TAP_W'(1);

   always_comb begin
      ram_wd.x1 = x_ff;
      ram_wd.x2 = hold_x1_ff;
      ram_wd.y1 = y_out;
      ram_wd.y2 = hold_y1_ff;
   end

   // blend and mix
   assign weight_a    = svc_pkg::FRAC_ONE - {1'b0, frac_ff};
   assign blend_sum   = blend_a_ff + blend_b_ff;
   assign blend32     = blend_sum[FB +: DW];
   assign rsp_data_in = dry_ff + blend32 + (mix_ff ? tap0_ff : DW'(0));

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      sec_in = sec_ff;
      if (accept) begin
         sec_in = '0;
      end else if (state_ff == svc_pkg::ST_ACC && !last_sec) begin
         sec_in = sec_ff + SEC_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svc_pkg::ST_IDLE;
         sec_ff       <= '0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= svc_pkg::MODE_RESET;
         mix_ff       <= svc_pkg::MIX_RESET;
         step_ff      <= svc_pkg::STEP_RESET;
         phase_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_rd_en) begin
            rd_valid_ff <= valid_ff[ram_rd_addr];
         end
         if (ram_wr_en) begin
            valid_ff[sec_ff] <= 1'b1;
         end
         if (accept) begin
            phase_ff <= phase_new;
         end
         if (csr_ch.valid) begin
            case (svc_pkg::csr_addr_type'(csr_ch.addr))
               svc_pkg::REG_MODE: mode_ff <= csr_ch.wdata[1:0];
               svc_pkg::REG_MIX:  mix_ff  <= csr_ch.wdata[0];
               svc_pkg::REG_STEP: step_ff <= csr_ch.wdata;
               default:           mix_ff  <= mix_ff;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff     <= x_half;
         tap0_ff  <= x_half;
         tap_a_ff <= x_half;
         tap_b_ff <= x_half;
         dry_ff   <= req_ch.dry_sample;
         frac_ff  <= phase_fold[FB-1:0];
         idx_a_ff <= TAP_W'(svc_pkg::tap_of(mode_ff, {1'b0, lfo_k}));
         idx_b_ff <= TAP_W'(svc_pkg::tap_of(mode_ff, {1'b0, lfo_k} + 4'd1));
      end
      if (state_ff == svc_pkg::ST_MUL) begin
         prod0_ff   <= AW'(tap_sum) * AW'(svc_pkg::COEF_A0);
         prod1_ff   <= AW'(st.y1) * AW'(svc_pkg::COEF_B1);
         prod2_ff   <= AW'(st.y2) * AW'(svc_pkg::COEF_B2);
         hold_x1_ff <= st.x1;
         hold_y1_ff <= st.y1;
      end
      if (state_ff == svc_pkg::ST_ACC) begin
         // section output feeds the next section and may be a selected tap
         x_ff <= y_out;
         if (idx_a_ff == tap_pos) tap_a_ff <= y_out;
         if (idx_b_ff == tap_pos) tap_b_ff <= y_out;
      end
      if (state_ff == svc_pkg::ST_BLEND) begin
         blend_a_ff <= BW'(tap_a_ff) * BW'($signed({1'b0, weight_a}));
         blend_b_ff <= BW'(tap_b_ff) * BW'($signed({2'b00, frac_ff}));
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.mixed_sample = rsp_data_ff;
   assign csr_ch.ready        = 1'b1;

endmodule

FILE: rtl/svc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module svc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/svc_checker.sv
// Port-level checker for scanner_vibrato_chorus, bound to the top level.
// Depends on scanner_vibrato_chorus_macros.svh.
`include "scanner_vibrato_chorus_macros.svh"

module svc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_mixed_sample
);

   // hold a stalled result
   `SVC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
   `SVC_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_mixed_sample), "rsp changed while stalled")
   // an accepted item keeps the block busy
   `SVC_ASSERT_NXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   // no result appears in the cycle after an accept made while none was waiting
   `SVC_ASSERT_NXT(a_latency, clock, reset, req_valid && req_ready && !rsp_valid, !rsp_valid, "result too early")

endmodule

bind scanner_vibrato_chorus svc_checker u_svc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_mixed_sample (rsp_ch.mixed_sample)
);
